// ===== hdl/tsb_pkg.sv =====
package tsb_pkg;

  // default bank size
  localparam int DEF_TIMER_SLOTS = 16;

  // most expiries reported by one service item
  localparam int MAX_RESULTS = 16;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int REQ_W   = 3;
  localparam int COUNT_W = 32;
  localparam int TAG_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int KIND_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CREATE_ONE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE_PER = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SERVICE    = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CREATED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAILED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  // per-slot data that only a create writes
  typedef struct packed {
    logic               periodic;
    logic [COUNT_W-1:0] reload;
    logic [TAG_W-1:0]   tag;
  } slot_info_t;

  // write strobes from the sequencer to the slot store
  typedef struct packed {
    logic cnt_we;
    logic info_we;
  } mem_ctl_t;

endpackage

// ===== hdl/tsb_slot_mem.sv =====
module tsb_slot_mem #(
  parameter int TIMER_SLOTS = tsb_pkg::DEF_TIMER_SLOTS
) (
  input  logic                                   clk,
  input  tsb_pkg::mem_ctl_t                      ctl,
  input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] wr_addr,
  input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] rd_addr,
  input  logic [tsb_pkg::COUNT_W-1:0]            cnt_wdata,
  input  tsb_pkg::slot_info_t                    info_wdata,
  output logic [tsb_pkg::COUNT_W-1:0]            cnt_rdata,
  output tsb_pkg::slot_info_t                    info_rdata
);
  import tsb_pkg::*;

  // count store and create-time info store, one write and one read port each
  logic [COUNT_W-1:0] cnt_mem  [TIMER_SLOTS];
  slot_info_t         info_mem [TIMER_SLOTS];

  // count store
  always_ff @(posedge clk) begin
    if (ctl.cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[rd_addr];
  end

  // info store
  always_ff @(posedge clk) begin
    if (ctl.info_we) begin
      info_mem[wr_addr] <= info_wdata;
    end
    info_rdata <= info_mem[rd_addr];
  end

endmodule

// ===== hdl/timer_slot_bank.sv =====
// timer slot bank: one slot visited per cycle by a shared count unit
// create: walks up from slot 0 and takes the lowest free slot, failing if none is free;
//   tick walks every slot, service every slot or until MAX_RESULTS expiries are found,
//   with busy high throughout; each walk is paced by the single read port of the count store
// service results come out one per found expiry, the last one at the end of the walk
// results are strobed for one cycle and cannot be stalled; reset frees every slot
module timer_slot_bank #(
  parameter int TIMER_SLOTS = tsb_pkg::DEF_TIMER_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tsb_pkg::REQ_W-1:0]    req_type,
  input  logic [tsb_pkg::COUNT_W-1:0]  timeout,
  input  logic [tsb_pkg::TAG_W-1:0]    handler_tag,
  input  logic [tsb_pkg::SLOT_W-1:0]   slot,
  output logic                         strobe,
  output logic [tsb_pkg::KIND_W-1:0]   kind,
  output logic [tsb_pkg::SLOT_W-1:0]   slot_out,
  output logic [tsb_pkg::TAG_W-1:0]    tag_out,
  output logic                         last
);
  import tsb_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_CREATE, S_TICK, S_SERVICE} state_t;

  state_t             state;
  logic               item_per;
  logic [COUNT_W-1:0] item_timeout;
  logic [TAG_W-1:0]   item_tag;
  logic [CW-1:0]      rd_idx;
  logic               p_valid;
  logic [SW-1:0]      p_idx;
  logic [NW-1:0]      n_found;
  logic               pend_valid;
  logic [SW-1:0]      pend_slot;
  logic [TAG_W-1:0]   pend_tag;
  logic [TIMER_SLOTS-1:0] used;

  mem_ctl_t           mem_ctl;
  logic [SW-1:0]      rd_addr;
  logic [SW-1:0]      wr_addr;
  logic [SW-1:0]      cancel_idx;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [COUNT_W-1:0] cnt_dec;
  slot_info_t         info_wdata;
  slot_info_t         info_rdata;
  logic               rd_end;
  logic               cnt_zero;
  logic               at_limit;
  logic               p_live;
  logic               cr_hit;
  logic               found;
  logic               srv_done;

  assign busy = (state != S_IDLE);

  // walk position and shared count unit
  assign rd_addr    = rd_idx[SW-1:0];
  assign rd_end     = (rd_idx == CW'(TIMER_SLOTS));
  assign cnt_zero   = (cnt_rdata == '0);
  assign cnt_dec    = cnt_rdata - COUNT_W'(1);
  assign at_limit   = (n_found == NW'(MAX_RESULTS));
  assign cancel_idx = SW'(slot);

  // slot conditions for the current step
  assign p_live   = p_valid && used[p_idx];
  assign cr_hit   = (state == S_CREATE) && !rd_end && !used[rd_addr];
  assign found    = (state == S_SERVICE) && p_live && cnt_zero && !at_limit;
  assign srv_done = at_limit || (rd_end && !p_valid);

  // store writes
  always_comb begin
    mem_ctl.info_we = cr_hit;
    mem_ctl.cnt_we  = cr_hit
                   || ((state == S_TICK) && p_live && !cnt_zero)
                   || (found && info_rdata.periodic);
    wr_addr = (state == S_CREATE) ? rd_addr : p_idx;
    unique case (state)
      S_CREATE: cnt_wdata = item_timeout;
      S_TICK:   cnt_wdata = cnt_dec;
      default:  cnt_wdata = info_rdata.reload;
    endcase
    info_wdata.periodic = item_per;
    info_wdata.reload   = item_per ? item_timeout : '0;
    info_wdata.tag      = item_tag;
  end

  tsb_slot_mem #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .cnt_wdata  (cnt_wdata),
    .info_wdata (info_wdata),
    .cnt_rdata  (cnt_rdata),
    .info_rdata (info_rdata)
  );

  // sequencer, used bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      p_valid    <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_per     <= (req_type == REQ_CREATE_PER);
            item_timeout <= timeout;
            item_tag     <= handler_tag;
            rd_idx       <= '0;
            p_valid      <= 1'b0;
            n_found      <= '0;
            pend_valid   <= 1'b0;
            unique case (req_type)
              REQ_CREATE_ONE, REQ_CREATE_PER: state <= S_CREATE;
              REQ_CANCEL: begin
                if (((SW + SLOT_W)'(slot) < (SW + SLOT_W)'(TIMER_SLOTS))) begin
                  used[cancel_idx] <= 1'b0;
                end
              end
              REQ_TICK:    state <= S_TICK;
              REQ_SERVICE: state <= S_SERVICE;
              default: ;
            endcase
          end
        end

        S_CREATE: begin
          if (rd_end) begin
            strobe   <= 1'b1;
            kind     <= KIND_FAILED;
            slot_out <= '0;
            tag_out  <= '0;
            last     <= 1'b1;
            state    <= S_IDLE;
          end else if (cr_hit) begin
            used[rd_addr] <= 1'b1;
            strobe   <= 1'b1;
            kind     <= KIND_CREATED;
            slot_out <= SLOT_W'(rd_addr);
            tag_out  <= '0;
            last     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            rd_idx <= rd_idx + CW'(1);
          end
        end

        S_TICK: begin
          if (!rd_end) begin
            p_valid <= 1'b1;
            p_idx   <= rd_addr;
            rd_idx  <= rd_idx + CW'(1);
          end else begin
            p_valid <= 1'b0;
            if (!p_valid) begin
              state <= S_IDLE;
            end
          end
        end

        S_SERVICE: begin
          if (srv_done) begin
            // flush the held expiry as the final result
            p_valid <= 1'b0;
            if (pend_valid) begin
              strobe   <= 1'b1;
              kind     <= KIND_EXPIRED;
              slot_out <= SLOT_W'(pend_slot);
              tag_out  <= pend_tag;
              last     <= 1'b1;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end else begin
            if (!rd_end) begin
              p_valid <= 1'b1;
              p_idx   <= rd_addr;
              rd_idx  <= rd_idx + CW'(1);
            end else begin
              p_valid <= 1'b0;
            end
            // hold each expiry until the next one shows it was not the last
            if (found) begin
              n_found <= n_found + NW'(1);
              if (!info_rdata.periodic) begin
                used[p_idx] <= 1'b0;
              end
              if (pend_valid) begin
                strobe   <= 1'b1;
                kind     <= KIND_EXPIRED;
                slot_out <= SLOT_W'(pend_slot);
                tag_out  <= pend_tag;
                last     <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_slot  <= p_idx;
              pend_tag   <= info_rdata.tag;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tsb_pkg::*;

  localparam int SLOTS        = DEF_TIMER_SLOTS;
  localparam int PLAN_LEN     = 25;
  localparam int RANDOM_ITEMS = 125;
  localparam int CALM_FROM    = 100;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_SHOWN    = 10;

  // request codes the block does not decode
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } timer_event_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [COUNT_W-1:0] tmo;
    logic [TAG_W-1:0]   tg;
    logic [SLOT_W-1:0]  sl;
    logic               typed;
    logic [KIND_W-1:0]  exp_kind;
    logic [SLOT_W-1:0]  exp_slot;
  } stim_row_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic [REQ_W-1:0]   req_type    = '0;
  logic [COUNT_W-1:0] timeout     = '0;
  logic [TAG_W-1:0]   handler_tag = '0;
  logic [SLOT_W-1:0]  slot        = '0;
  logic               strobe;
  logic [KIND_W-1:0]  kind;
  logic [SLOT_W-1:0]  slot_out;
  logic [TAG_W-1:0]   tag_out;
  logic               last;

  // predicted state of the slot bank
  bit                 bank_used     [SLOTS];
  logic [COUNT_W-1:0] bank_count    [SLOTS];
  logic [COUNT_W-1:0] bank_reload   [SLOTS];
  bit                 bank_periodic [SLOTS];
  logic [TAG_W-1:0]   bank_tag      [SLOTS];

  timer_event_t expected_events[$];
  stim_row_t    plan[PLAN_LEN];

  int errors       = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;
  int seen_created = 0;
  int seen_refused = 0;
  int seen_expired = 0;

  timer_slot_bank #(
    .TIMER_SLOTS(SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .timeout(timeout),
    .handler_tag(handler_tag),
    .slot(slot),
    .strobe(strobe),
    .kind(kind),
    .slot_out(slot_out),
    .tag_out(tag_out),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic stim_row_t row(input logic [REQ_W-1:0] r, input logic [COUNT_W-1:0] t,
                                    input logic [TAG_W-1:0] g, input logic [SLOT_W-1:0] s,
                                    input logic typed = 1'b0,
                                    input logic [KIND_W-1:0] k = KIND_CREATED,
                                    input logic [SLOT_W-1:0] es = '0);
    stim_row_t x;
    x = '{req: r, tmo: t, tg: g, sl: s, typed: typed, exp_kind: k, exp_slot: es};
    return x;
  endfunction

  task automatic release_slot(input int s);
    bank_used[s]     = 1'b0;
    bank_count[s]    = '0;
    bank_reload[s]   = '0;
    bank_periodic[s] = 1'b0;
    bank_tag[s]      = '0;
  endtask

  // update the predicted bank for one accepted item and queue what it should report
  task automatic predict_request(input logic [REQ_W-1:0] r, input logic [COUNT_W-1:0] t,
                                 input logic [TAG_W-1:0] g, input logic [SLOT_W-1:0] s_in,
                                 input bit record, output bit effective);
    int           free_idx;
    int           total;
    int           n;
    timer_event_t ev;
    free_idx  = -1;
    total     = 0;
    n         = 0;
    effective = 1'b1;
    case (r)
      REQ_CREATE_ONE, REQ_CREATE_PER: begin
        for (int s = SLOTS - 1; s >= 0; s--) if (!bank_used[s]) free_idx = s;
        ev = '{kind: KIND_FAILED, slot: '0, tag: '0, last: 1'b1};
        if (free_idx >= 0) begin
          bank_used[free_idx]  = 1'b1;
          bank_count[free_idx] = t;
          bank_tag[free_idx]   = g;
          if (r == REQ_CREATE_PER) begin
            bank_periodic[free_idx] = 1'b1;
            bank_reload[free_idx]   = t;
          end
          ev.kind = KIND_CREATED;
          ev.slot = free_idx[SLOT_W-1:0];
        end
        if (record) expected_events.push_back(ev);
      end
      REQ_CANCEL: begin
        if (int'(s_in) < SLOTS && bank_used[s_in]) release_slot(int'(s_in));
        else effective = 1'b0;
      end
      REQ_TICK: begin
        for (int s = 0; s < SLOTS; s++)
          if (bank_used[s] && bank_count[s] != '0) bank_count[s] = bank_count[s] - 1'b1;
      end
      REQ_SERVICE: begin
        // count first so the final report can carry last
        for (int s = 0; s < SLOTS && total < MAX_RESULTS; s++)
          if (bank_used[s] && bank_count[s] == '0) total++;
        for (int s = 0; s < SLOTS && n < total; s++) begin
          if (bank_used[s] && bank_count[s] == '0) begin
            ev = '{kind: KIND_EXPIRED, slot: s[SLOT_W-1:0], tag: bank_tag[s],
                   last: (n == total - 1)};
            if (record) expected_events.push_back(ev);
            n++;
            if (bank_periodic[s]) bank_count[s] = bank_reload[s];
            else release_slot(s);
          end
        end
      end
      default: effective = 1'b0;
    endcase
  endtask

  // present one item and hold it until the block takes it
  task automatic issue(input logic [REQ_W-1:0] r, input logic [COUNT_W-1:0] t,
                       input logic [TAG_W-1:0] g, input logic [SLOT_W-1:0] s);
    start       <= 1'b1;
    req_type    <= r;
    timeout     <= t;
    handler_tag <= g;
    slot        <= s;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // compare every strobed result with the oldest expectation
  always @(posedge clk) begin : check_results
    timer_event_t got;
    timer_event_t want;
    if (!rst && strobe) begin
      got = '{kind: kind, slot: slot_out, tag: tag_out, last: last};
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected result: kind %0d slot %0d tag %h last %0d",
                   got.kind, got.slot, got.tag, got.last);
      end else begin
        want = expected_events.pop_front();
        case (want.kind)
          KIND_CREATED: seen_created++;
          KIND_FAILED:  seen_refused++;
          default:      seen_expired++;
        endcase
        if (got.kind != want.kind || got.slot != want.slot || got.tag != want.tag ||
            got.last != want.last) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display({"mismatch at %0t: expected kind %0d slot %0d tag %h last %0d, ",
                      "got kind %0d slot %0d tag %h last %0d"},
                     $realtime, want.kind, want.slot, want.tag, want.last,
                     got.kind, got.slot, got.tag, got.last);
        end
      end
    end
  end

  // stop the run if neither side moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int                 counted;
    int                 pick;
    bit                 effective;
    logic [REQ_W-1:0]   r;
    logic [COUNT_W-1:0] t;
    logic [TAG_W-1:0]   g;
    logic [SLOT_W-1:0]  s;
    int                 live[$];

    // directed items: fill the bank, refuse, expire, cancel, odd codes
    plan[0]  = row(REQ_CREATE_ONE, 32'h0000_0000, 16'hFFFF, 4'd0, 1'b1, KIND_CREATED, 4'd0);
    plan[1]  = row(REQ_CREATE_PER, 32'h0000_0000, 16'h0000, 4'd15, 1'b1, KIND_CREATED, 4'd1);
    plan[2]  = row(REQ_CREATE_ONE, 32'hFFFF_FFFF, 16'h1234, 4'd10, 1'b1, KIND_CREATED, 4'd2);
    plan[3]  = row(REQ_CREATE_PER, 32'd1, 16'h8003, 4'd3);
    plan[4]  = row(REQ_CREATE_ONE, 32'd1, 16'h4004, 4'd4);
    plan[5]  = row(REQ_CREATE_PER, 32'd1, 16'h2005, 4'd5);
    plan[6]  = row(REQ_CREATE_ONE, 32'd1, 16'h1006, 4'd6);
    plan[7]  = row(REQ_CREATE_PER, 32'd1, 16'h0807, 4'd7);
    plan[8]  = row(REQ_CREATE_ONE, 32'd1, 16'h0408, 4'd8);
    plan[9]  = row(REQ_CREATE_PER, 32'd1, 16'h0209, 4'd9);
    plan[10] = row(REQ_CREATE_ONE, 32'd1, 16'h010A, 4'd10);
    plan[11] = row(REQ_CREATE_PER, 32'd1, 16'h00BB, 4'd11);
    plan[12] = row(REQ_CREATE_ONE, 32'd1, 16'h004C, 4'd12);
    plan[13] = row(REQ_CREATE_PER, 32'd1, 16'h002D, 4'd13);
    plan[14] = row(REQ_CREATE_ONE, 32'd1, 16'h001E, 4'd14);
    plan[15] = row(REQ_CREATE_ONE, 32'd1, 16'h7FFF, 4'd15);
    plan[16] = row(REQ_CREATE_PER, 32'd5, 16'hBEEF, 4'd0, 1'b1, KIND_FAILED, 4'd0);
    plan[17] = row(REQ_TICK, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
    plan[18] = row(REQ_SERVICE, 32'h0, 16'h0, 4'd0);
    plan[19] = row(REQ_SERVICE, 32'h5555_5555, 16'hAAAA, 4'd5);
    plan[20] = row(REQ_CANCEL, 32'h0, 16'h0, 4'd1);
    plan[21] = row(REQ_CANCEL, 32'h0, 16'h0, 4'd15);
    plan[22] = row(REQ_SERVICE, 32'h0, 16'h0, 4'd0);
    plan[23] = row(REQ_UNUSED_LO, 32'h0, 16'h0, 4'd0);
    plan[24] = row(REQ_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);

    for (int i = 0; i < SLOTS; i++) release_slot(i);
    counted = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < PLAN_LEN; i++) begin
      issue(plan[i].req, plan[i].tmo, plan[i].tg, plan[i].sl);
      predict_request(plan[i].req, plan[i].tmo, plan[i].tg, plan[i].sl,
                      !plan[i].typed, effective);
      if (plan[i].typed)
        expected_events.push_back('{kind: plan[i].exp_kind, slot: plan[i].exp_slot,
                                    tag: '0, last: 1'b1});
      if ($urandom_range(0, 99) < 30) pause_sender($urandom_range(1, 17));
    end
    drain_results();

    // random part: short counts so slots expire, mixed with wide values
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      g    = TAG_W'($urandom);
      s    = SLOT_W'($urandom);
      if (pick < 22) r = REQ_CREATE_ONE;
      else if (pick < 37) r = REQ_CREATE_PER;
      else if (pick < 50) r = REQ_CANCEL;
      else if (pick < 75) r = REQ_TICK;
      else if (pick < 95) r = REQ_SERVICE;
      else r = REQ_UNUSED_LO + REQ_W'($urandom_range(0, REQ_UNUSED_HI - REQ_UNUSED_LO));

      pick = $urandom_range(0, 99);
      if (pick < 15) t = '0;
      else if (pick < 65) t = $urandom_range(1, 4);
      else if (pick < 80) t = $urandom;
      else if (pick < 85) t = '1;
      else t = $urandom_range(5, 20);

      // cancels mostly hit a slot in use
      if (r == REQ_CANCEL && $urandom_range(0, 99) < 75) begin
        live.delete();
        for (int i = 0; i < SLOTS; i++) if (bank_used[i]) live.push_back(i);
        if (live.size() != 0) s = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
      end

      issue(r, t, g, s);
      predict_request(r, t, g, s, 1'b1, effective);
      if (effective) counted++;

      if (counted < CALM_FROM) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) drain_results();
        else if (pick < 33) pause_sender($urandom_range(1, 17));
      end
    end

    // let the last results and any trailing walk finish
    drain_results();
    repeat (SLOTS + 4) @(posedge clk);
    if (expected_events.size() != 0) errors++;

    $display("%0d items sent (%0d directed), %0d results checked", items_sent, PLAN_LEN,
             seen_created + seen_refused + seen_expired);
    $display("created %0d, refused %0d, expiries %0d, failures %0d", seen_created,
             seen_refused, seen_expired, errors);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tsb_pkg.sv
hdl/tsb_slot_mem.sv
hdl/timer_slot_bank.sv
tb/testbench.sv
